[rtl/ptw_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and field layout of the four-level page table walker
// no dependencies; imported by every module of the block
package ptw_pkg;

	// default sizing, handed to the top level parameters
	localparam int NODE_COUNT_DEF = 64;
	localparam int LEVEL_BITS_DEF = 9;
	localparam int FRAME_BITS_DEF = 28;

	// fixed field widths
	localparam int CMD_W      = 2;
	localparam int PAGE_W     = 36;
	localparam int FRAME_IN_W = 28;
	localparam int COUNT_W    = 10;
	localparam int VA_W       = 48;
	localparam int OFFSET_W   = 12;
	localparam int STATUS_W   = 3;
	localparam int PA_W       = 40;

	// stream layout, lowest field first
	localparam int IN_TDATA_W   = 128;
	localparam int IN_PAGE_LSB  = 0;
	localparam int IN_FRAME_LSB = IN_PAGE_LSB + PAGE_W;
	localparam int IN_COUNT_LSB = IN_FRAME_LSB + FRAME_IN_W;
	localparam int IN_VA_LSB    = IN_COUNT_LSB + COUNT_W;
	localparam int OUT_TDATA_W  = 48;
	localparam int OUT_OK_BIT   = 0;
	localparam int OUT_ST_LSB   = 1;
	localparam int OUT_PA_LSB   = OUT_ST_LSB + STATUS_W;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_PA_LSB - PA_W;

	// the leaf level of the walk
	localparam logic [1:0] LEAF_LEVEL = 2'd3;

	typedef enum logic [CMD_W-1:0] {
		CMD_MAP   = 2'd0,
		CMD_UNMAP = 2'd1,
		CMD_XLATE = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_PAGE_ZERO  = 3'd1,
		ST_MAPPED     = 3'd2,
		ST_NOT_MAPPED = 3'd3,
		ST_POOL_FULL  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ADV,
		S_WALK,
		S_FIN
	} ptw_state_t;

	// node store port strobes
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

[rtl/ptw_node_store.sv]
`timescale 1ns / 1ps
// node store: one write port, one read port with registered read data
// depends on ptw_pkg for the port strobe struct
module ptw_node_store import ptw_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int LEVEL_BITS = LEVEL_BITS_DEF,
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic                                     clk,
	input  mem_ctl_t                                 ctl,
	input  logic [$clog2(NODE_COUNT)+LEVEL_BITS-1:0] wr_addr,
	input  logic [FRAME_BITS:0]                      wr_data,
	input  logic [$clog2(NODE_COUNT)+LEVEL_BITS-1:0] rd_addr,
	output logic [FRAME_BITS:0]                      rd_data
);

	localparam int DEPTH   = NODE_COUNT << LEVEL_BITS;
	localparam int STORE_W = FRAME_BITS + 1;

	logic [STORE_W-1:0] mem [DEPTH];
	logic [STORE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/ptw_ctrl.sv]
`timescale 1ns / 1ps
// walk sequencer: clearing pass, map / unmap / translate walks, node pool, result register
// depends on ptw_pkg; drives ptw_node_store
module ptw_ctrl import ptw_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int LEVEL_BITS = LEVEL_BITS_DEF,
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  cmd_t                                     in_cmd,
	input  logic [PAGE_W-1:0]                        in_page,
	input  logic [FRAME_IN_W-1:0]                    in_frame,
	input  logic [COUNT_W-1:0]                       in_count,
	input  logic [VA_W-1:0]                          in_va,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic                                     out_ok,
	output status_t                                  out_status,
	output logic [PA_W-1:0]                          out_pa,
	output mem_ctl_t                                 mem_ctl,
	output logic [$clog2(NODE_COUNT)+LEVEL_BITS-1:0] wr_addr,
	output logic [FRAME_BITS:0]                      wr_data,
	output logic [$clog2(NODE_COUNT)+LEVEL_BITS-1:0] rd_addr,
	input  logic [FRAME_BITS:0]                      rd_data
);

	localparam int NODE_W  = $clog2(NODE_COUNT);
	localparam int ADDR_W  = NODE_W + LEVEL_BITS;
	localparam int DEPTH   = NODE_COUNT << LEVEL_BITS;
	localparam int STORE_W = FRAME_BITS + 1;
	localparam int FREE_W  = $clog2(NODE_COUNT + 1);

	function automatic logic [LEVEL_BITS-1:0] level_idx(input logic [PAGE_W-1:0] pg,
		input logic [1:0] lv);
		logic [PAGE_W-1:0] sh;
		sh = pg >> (lv * LEVEL_BITS);
		return sh[LEVEL_BITS-1:0];
	endfunction

	ptw_state_t           state_q, state_d;
	logic [ADDR_W-1:0]    clr_addr_q, clr_addr_d;
	cmd_t                 cmd_q, cmd_d;
	logic [PAGE_W-1:0]    page_q, page_d;
	logic [FRAME_BITS-1:0] frame_q, frame_d;
	logic [COUNT_W-1:0]   cnt_q, cnt_d;
	logic [OFFSET_W-1:0]  off_q, off_d;
	logic                 any_q, any_d;
	logic [NODE_W-1:0]    node_q, node_d;
	logic [1:0]           level_q, level_d;
	logic [FREE_W-1:0]    free_q, free_d;

	logic                 out_valid_q;
	logic                 out_ok_q;
	status_t              out_st_q;
	logic [PA_W-1:0]      out_pa_q;
	status_t              hold_st_q;
	logic [PA_W-1:0]      hold_pa_q;

	logic                 fin;
	status_t              fin_st;
	logic [PA_W-1:0]      fin_pa;
	logic                 descend;
	logic                 nxt_page;
	logic                 slot_free;
	logic                 link_ok;
	logic                 leaf_valid;
	logic                 pool_full;
	logic [NODE_W-1:0]    next_node;
	logic [ADDR_W-1:0]    slot;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d    = state_q;
		clr_addr_d = clr_addr_q;
		cmd_d      = cmd_q;
		page_d     = page_q;
		frame_d    = frame_q;
		cnt_d      = cnt_q;
		off_d      = off_q;
		any_d      = any_q;
		node_d     = node_q;
		level_d    = level_q;
		free_d     = free_q;
		in_ready   = 1'b0;
		mem_ctl    = '0;
		wr_addr    = '0;
		wr_data    = '0;
		rd_addr    = '0;
		fin        = 1'b0;
		fin_st     = ST_NOT_MAPPED;
		fin_pa     = '1;
		descend    = 1'b0;
		nxt_page   = 1'b0;

		slot       = {node_q, level_idx(page_q, level_q)};
		link_ok    = (rd_data != '0) && (rd_data < STORE_W'(NODE_COUNT));
		leaf_valid = rd_data[FRAME_BITS];
		pool_full  = free_q >= FREE_W'(NODE_COUNT);
		next_node  = link_ok ? rd_data[NODE_W-1:0] : free_q[NODE_W-1:0];

		unique case (state_q)
			S_CLEAR: begin
				mem_ctl.wr_en = 1'b1;
				wr_addr       = clr_addr_q;
				clr_addr_d    = clr_addr_q + ADDR_W'(1);
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_d = in_cmd;
					case (in_cmd) inside
						CMD_MAP, CMD_UNMAP: begin
							if (in_page == '0) begin
								fin    = 1'b1;
								fin_st = ST_PAGE_ZERO;
							end else begin
								page_d  = in_page;
								cnt_d   = in_count;
								frame_d = FRAME_BITS'(in_frame);
								any_d   = 1'b0;
								state_d = S_ADV;
							end
						end
						CMD_XLATE: begin
							if (in_va[VA_W-1:OFFSET_W] == '0) begin
								fin = 1'b1;
							end else begin
								page_d        = in_va[VA_W-1:OFFSET_W];
								off_d         = in_va[OFFSET_W-1:0];
								node_d        = '0;
								level_d       = '0;
								mem_ctl.rd_en = 1'b1;
								rd_addr       = {NODE_W'(0), level_idx(in_va[VA_W-1:OFFSET_W], 2'd0)};
								state_d       = S_WALK;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_ADV: begin
				if (cnt_q == '0) begin
					fin    = 1'b1;
					fin_st = (cmd_q == CMD_UNMAP && !any_q) ? ST_NOT_MAPPED : ST_OK;
				end else if (page_q == '0) begin
					// the run wrapped onto page zero
					if (cmd_q == CMD_MAP) begin
						fin    = 1'b1;
						fin_st = ST_PAGE_ZERO;
					end else begin
						nxt_page = 1'b1;
					end
				end else begin
					mem_ctl.rd_en = 1'b1;
					rd_addr       = {NODE_W'(0), level_idx(page_q, 2'd0)};
					node_d        = '0;
					level_d       = '0;
					state_d       = S_WALK;
				end
			end
			S_WALK: begin
				if (level_q != LEAF_LEVEL) begin
					if (link_ok) begin
						descend = 1'b1;
					end else if (cmd_q == CMD_MAP) begin
						if (pool_full) begin
							fin    = 1'b1;
							fin_st = ST_POOL_FULL;
						end else begin
							mem_ctl.wr_en = 1'b1;
							wr_addr       = slot;
							wr_data       = STORE_W'(free_q);
							free_d        = free_q + FREE_W'(1);
							descend       = 1'b1;
						end
					end else if (cmd_q == CMD_UNMAP) begin
						nxt_page = 1'b1;
					end else begin
						fin = 1'b1;
					end
				end else begin
					case (cmd_q)
						CMD_MAP: begin
							if (leaf_valid) begin
								fin    = 1'b1;
								fin_st = ST_MAPPED;
							end else begin
								mem_ctl.wr_en = 1'b1;
								wr_addr       = slot;
								wr_data       = {1'b1, frame_q};
								nxt_page      = 1'b1;
							end
						end
						CMD_UNMAP: begin
							if (leaf_valid) begin
								mem_ctl.wr_en = 1'b1;
								wr_addr       = slot;
								wr_data       = {1'b0, rd_data[FRAME_BITS-1:0]};
								any_d         = 1'b1;
							end
							nxt_page = 1'b1;
						end
						default: begin
							fin = 1'b1;
							if (leaf_valid) begin
								fin_st = ST_OK;
								fin_pa = PA_W'({rd_data[FRAME_BITS-1:0], off_q});
							end
						end
					endcase
				end
			end
			S_FIN: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// next level read overlaps the decision on this one
		if (descend) begin
			mem_ctl.rd_en = 1'b1;
			rd_addr       = {next_node, level_idx(page_q, level_q + 2'd1)};
			node_d        = next_node;
			level_d       = level_q + 2'd1;
		end
		if (nxt_page) begin
			page_d  = page_q + PAGE_W'(1);
			cnt_d   = cnt_q - COUNT_W'(1);
			frame_d = frame_q + FRAME_BITS'(1);
			state_d = S_ADV;
		end
		if (fin) begin
			state_d = slot_free ? S_IDLE : S_FIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			free_q      <= FREE_W'(1);
			cmd_q       <= CMD_MAP;
			any_q       <= 1'b0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_addr_q <= clr_addr_d;
			free_q     <= free_d;
			cmd_q      <= cmd_d;
			any_q      <= any_d;
			level_q    <= level_d;
			if ((fin || state_q == S_FIN) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		page_q  <= page_d;
		frame_q <= frame_d;
		cnt_q   <= cnt_d;
		off_q   <= off_d;
		node_q  <= node_d;
		if (fin && !slot_free) begin
			hold_st_q <= fin_st;
			hold_pa_q <= fin_pa;
		end
		if (fin && slot_free) begin
			out_ok_q <= (fin_st == ST_OK);
			out_st_q <= fin_st;
			out_pa_q <= fin_pa;
		end else if (state_q == S_FIN && slot_free) begin
			out_ok_q <= (hold_st_q == ST_OK);
			out_st_q <= hold_st_q;
			out_pa_q <= hold_pa_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_ok     = out_ok_q;
	assign out_status = out_st_q;
	assign out_pa     = out_pa_q;

endmodule

[rtl/four_level_page_table_walker.sv]
`timescale 1ns / 1ps
// top level of the four-level page table walker: stream ports, sequencer and node store
// depends on ptw_pkg, ptw_ctrl and ptw_node_store

// A radix page table of four LEVEL_BITS-wide levels over a 36-bit page number, root level
// indexed by the lowest bits, held in one synchronous node store of NODE_COUNT nodes of
// 2^LEVEL_BITS entries. Each input transaction (command in tuser) gives exactly one result
// transaction. After reset the store is swept to zero, one entry a cycle, over all
// NODE_COUNT * 2^LEVEL_BITS entries (32768 at the default sizing); s_axis_tready stays low
// until the sweep ends. Every walk level costs one read of the node store, issued in the
// same cycle that the previous level's entry is examined: a translate issues the root read
// on acceptance, then examines the four levels in turn and ends early on a missing interior
// node; a translate of page zero ends on acceptance. Map and unmap walk each page of the run
// in the same way after an advance step; an unmap page whose walk meets a missing node moves
// on to the next page, a map run ends at the page that fails, and an unmap skips a page that
// wrapped onto page zero. Map or unmap of page zero and an unknown command end on acceptance.
// A result waiting on m_axis_tready does not block the next acceptance; a second result
// finishing behind it is held in a one-deep register and the input stays closed until the
// waiting one leaves.
module four_level_page_table_walker import ptw_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int LEVEL_BITS = LEVEL_BITS_DEF,
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// page [35:0], frame [63:36], count [73:64], va [121:74], zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// command [1:0]
	input  logic [CMD_W-1:0]       s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// ok [0], status [3:1], physical_address [43:4], zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int ADDR_W = $clog2(NODE_COUNT) + LEVEL_BITS;

	// unpacked input fields
	cmd_t                  in_cmd;
	logic [PAGE_W-1:0]     in_page;
	logic [FRAME_IN_W-1:0] in_frame;
	logic [COUNT_W-1:0]    in_count;
	logic [VA_W-1:0]       in_va;

	// result fields
	logic                  out_ok;
	status_t               out_status;
	logic [PA_W-1:0]       out_pa;

	// node store port
	mem_ctl_t              mem_ctl;
	logic [ADDR_W-1:0]     wr_addr;
	logic [FRAME_BITS:0]   wr_data;
	logic [ADDR_W-1:0]     rd_addr;
	logic [FRAME_BITS:0]   rd_data;

	assign in_cmd   = cmd_t'(s_axis_tuser);
	assign in_page  = s_axis_tdata[IN_PAGE_LSB +: PAGE_W];
	assign in_frame = s_axis_tdata[IN_FRAME_LSB +: FRAME_IN_W];
	assign in_count = s_axis_tdata[IN_COUNT_LSB +: COUNT_W];
	assign in_va    = s_axis_tdata[IN_VA_LSB +: VA_W];

	// sequencer: clearing sweep, walks, node pool and the result register
	ptw_ctrl #(
		.NODE_COUNT (NODE_COUNT),
		.LEVEL_BITS (LEVEL_BITS),
		.FRAME_BITS (FRAME_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_cmd     (in_cmd),
		.in_page    (in_page),
		.in_frame   (in_frame),
		.in_count   (in_count),
		.in_va      (in_va),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_ok     (out_ok),
		.out_status (out_status),
		.out_pa     (out_pa),
		.mem_ctl    (mem_ctl),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	// interior entries hold child node links, leaf entries a valid bit above the frame
	ptw_node_store #(
		.NODE_COUNT (NODE_COUNT),
		.LEVEL_BITS (LEVEL_BITS),
		.FRAME_BITS (FRAME_BITS)
	) u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result packing, lowest field first
	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_pa, out_status, out_ok};

endmodule

[rtl/ptw_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the page table walker, bound to the top level
// depends on ptw_pkg and four_level_page_table_walker
module ptw_checker import ptw_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// ok flag agrees with the status code
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		m_axis_tdata[OUT_OK_BIT] == (m_axis_tdata[OUT_ST_LSB +: STATUS_W] == ST_OK))
		else $error("ok flag and status disagree");

	// failures carry an all-ones address
	a_fail_ones: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[OUT_OK_BIT] |-> m_axis_tdata[OUT_PA_LSB +: PA_W] == '1)
		else $error("failed result with a physical address");

	// the clearing sweep keeps the input closed right after reset
	a_clear_closed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !s_axis_tready)
		else $error("input open before the store sweep");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

[test/tb_four_level_page_table_walker.sv]
`timescale 1ns / 1ps
// self-checking testbench for four_level_page_table_walker: directed rows, then random traffic
// depends on ptw_pkg and the rtl of the walker; a behavioural mirror of the table predicts results
module tb_four_level_page_table_walker import ptw_pkg::*;;

	// sizing of the mirror, same as the instance defaults
	localparam int NODES      = NODE_COUNT_DEF;
	localparam int LVL        = LEVEL_BITS_DEF;
	localparam int FRM        = FRAME_BITS_DEF;
	localparam int NODE_SLOTS = NODES << LVL;
	localparam int MIRROR_W   = FRM + 1;

	// command code outside the enum, still legal on the bus
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	// low 27 bits of the page paths that the pool-exhaustion row allocates
	localparam logic [26:0]      PATH_BASE = 27'h2A51C3;
	localparam logic [26:0]      PATH_TOP  = 27'h7FFFFFF;
	localparam logic [PA_W-1:0]  PA_ALL    = '1;

	localparam int N_RANDOM     = 1475;
	localparam int DRAIN_CYCLES = 50;
	// clearing pass plus the traffic below, taken about ten times over
	localparam int unsigned CYCLE_LIMIT = 3_000_000;

	typedef struct {
		logic                  ok;
		status_t               status;
		logic [PA_W-1:0]       pa;
	} outcome_t;

	// one command transaction; the last three fields are a typed expectation when typed is set
	typedef struct {
		logic [CMD_W-1:0]      cmd;
		logic [PAGE_W-1:0]     page;
		logic [FRAME_IN_W-1:0] frame;
		logic [COUNT_W-1:0]    count;
		logic [VA_W-1:0]       va;
		bit                    typed;
		logic                  ok;
		status_t               status;
		logic [PA_W-1:0]       pa;
	} command_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [CMD_W-1:0]       s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// mirror of the node store and the allocation pointer
	logic [FRM:0]           node_mirror [NODE_SLOTS];
	int unsigned            mirror_next_node;

	outcome_t               pending_outcomes [$];
	int unsigned            error_count = 0;
	int unsigned            cycle_count = 0;
	int                     tx_idle_pct = 38;
	int                     rx_idle_pct = 52;

	// directed rows: extremes, every command, every status, run wrapping and pool exhaustion
	command_row_t directed_rows [25] = '{
		// translate of page zero misses
		'{CMD_XLATE, 36'd0, 28'd0, 10'd0, 48'd0, 1'b1, 1'b0, ST_NOT_MAPPED, PA_ALL},
		'{CMD_MAP, 36'd0, 28'd0, 10'd5, 48'd0, 1'b1, 1'b0, ST_PAGE_ZERO, PA_ALL},
		'{CMD_UNMAP, 36'd0, 28'd0, 10'd1023, 48'd0, 1'b1, 1'b0, ST_PAGE_ZERO, PA_ALL},
		// empty runs: unmap answers not mapped, map succeeds
		'{CMD_UNMAP, 36'd5, 28'd0, 10'd0, 48'd0, 1'b1, 1'b0, ST_NOT_MAPPED, PA_ALL},
		'{CMD_MAP, 36'd5, 28'hFFFFFFF, 10'd0, 48'd0, 1'b1, 1'b1, ST_OK, PA_ALL},
		'{CMD_XLATE, 36'd0, 28'd0, 10'd0, 48'hFFFFFFFFFFFF, 1'b1, 1'b0, ST_NOT_MAPPED, PA_ALL},
		'{CMD_UNKNOWN, 36'hFFFFFFFFF, 28'hFFFFFFF, 10'd1023, 48'hFFFFFFFFFFFF,
			1'b1, 1'b0, ST_NOT_MAPPED, PA_ALL},
		// top page maps, then the run wraps onto page zero
		'{CMD_MAP, 36'hFFFFFFFFF, 28'hFFFFFFF, 10'd2, 48'd0, 1'b1, 1'b0, ST_PAGE_ZERO, PA_ALL},
		'{CMD_XLATE, 36'd0, 28'd0, 10'd0, 48'hFFFFFFFFFFFF, 1'b0, 1'b0, ST_OK, 40'd0},
		'{CMD_MAP, 36'hFFFFFFFFF, 28'd0, 10'd1, 48'd0, 1'b1, 1'b0, ST_MAPPED, PA_ALL},
		// unmap skips the wrapped page zero
		'{CMD_UNMAP, 36'hFFFFFFFFF, 28'd0, 10'd2, 48'd0, 1'b1, 1'b1, ST_OK, PA_ALL},
		'{CMD_XLATE, 36'd0, 28'd0, 10'd0, 48'hFFFFFFFFFFFF, 1'b1, 1'b0, ST_NOT_MAPPED, PA_ALL},
		// an invalid leaf is free again
		'{CMD_MAP, 36'hFFFFFFFFF, 28'd0, 10'd1, 48'd0, 1'b1, 1'b1, ST_OK, PA_ALL},
		'{CMD_XLATE, 36'd0, 28'd0, 10'd0, {36'hFFFFFFFFF, 12'h000}, 1'b0, 1'b0, ST_OK, 40'd0},
		// long run exhausts the pool, frames wrap
		'{CMD_MAP, {9'd1, PATH_BASE}, 28'hFFFFFF0, 10'd1023, 48'd0,
			1'b1, 1'b0, ST_POOL_FULL, PA_ALL},
		'{CMD_XLATE, 36'd0, 28'd0, 10'd0, {9'd1, PATH_BASE + 27'd19, 12'hABC},
			1'b0, 1'b0, ST_OK, 40'd0},
		'{CMD_XLATE, 36'd0, 28'd0, 10'd0, {9'd1, PATH_BASE + 27'd20, 12'h001},
			1'b1, 1'b0, ST_NOT_MAPPED, PA_ALL},
		'{CMD_UNMAP, {9'd1, PATH_BASE + 27'd5}, 28'd0, 10'd1023, 48'd0,
			1'b0, 1'b0, ST_OK, 40'd0},
		'{CMD_UNMAP, {9'd1, PATH_BASE + 27'd5}, 28'd0, 10'd1023, 48'd0,
			1'b1, 1'b0, ST_NOT_MAPPED, PA_ALL},
		'{CMD_MAP, {9'd2, PATH_BASE}, 28'h1234567, 10'd20, 48'd0, 1'b0, 1'b0, ST_OK, 40'd0},
		'{CMD_MAP, {9'd2, PATH_BASE + 27'd19}, 28'd7, 10'd2, 48'd0,
			1'b1, 1'b0, ST_MAPPED, PA_ALL},
		'{CMD_XLATE, 36'd0, 28'd0, 10'd0, {9'd2, PATH_BASE + 27'd7, 12'h5A5},
			1'b0, 1'b0, ST_OK, 40'd0},
		// pool empty on the very first level
		'{CMD_MAP, 36'd1, 28'd9, 10'd1, 48'd0, 1'b1, 1'b0, ST_POOL_FULL, PA_ALL},
		'{CMD_XLATE, 36'd0, 28'd0, 10'd0, {9'd1, PATH_BASE + 27'd4, 12'hFFF},
			1'b0, 1'b0, ST_OK, 40'd0},
		'{CMD_UNMAP, {9'd2, PATH_BASE + 27'd7}, 28'd0, 10'd1, 48'd0, 1'b0, 1'b0, ST_OK, 40'd0}
	};

	four_level_page_table_walker u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// store slot of the entry a page uses at one level of the walk
	function automatic int unsigned slot_of_level(int unsigned node, logic [PAGE_W-1:0] page,
			int lvl);
		logic [PAGE_W-1:0] idx;
		idx = (page >> (lvl * LVL)) & ((PAGE_W'(1) << LVL) - 1);
		return ((node << LVL) | int'(idx)) % NODE_SLOTS;
	endfunction

	// walks the three interior levels, growing the tree when asked
	function automatic status_t descend(logic [PAGE_W-1:0] page, bit grow,
			output int unsigned leaf);
		int unsigned node;
		int unsigned s;
		int unsigned link;
		int          lvl;
		node = 0;
		leaf = 0;
		for (lvl = 0; lvl < 3; lvl++) begin
			s = slot_of_level(node, page, lvl);
			link = 32'(node_mirror[s]);
			if (link == 0 || link >= NODES) begin
				if (!grow)
					return ST_NOT_MAPPED;
				if (mirror_next_node >= NODES)
					return ST_POOL_FULL;
				link = mirror_next_node;
				mirror_next_node++;
				node_mirror[s] = MIRROR_W'(link);
			end
			node = link;
		end
		leaf = slot_of_level(node, page, LEAF_LEVEL);
		return ST_OK;
	endfunction

	function automatic status_t map_run(logic [PAGE_W-1:0] page, logic [FRAME_IN_W-1:0] frame,
			logic [COUNT_W-1:0] count);
		logic [PAGE_W-1:0] p;
		int unsigned       leaf;
		status_t           st;
		int                i;
		if (page == 0)
			return ST_PAGE_ZERO;
		for (i = 0; i < count; i++) begin
			p = page + PAGE_W'(i);
			if (p == 0)
				return ST_PAGE_ZERO;
			st = descend(p, 1'b1, leaf);
			if (st != ST_OK)
				return st;
			if (node_mirror[leaf][FRM])
				return ST_MAPPED;
			node_mirror[leaf] = {1'b1, frame + FRM'(i)};
		end
		return ST_OK;
	endfunction

	function automatic status_t unmap_run(logic [PAGE_W-1:0] page, logic [COUNT_W-1:0] count);
		logic [PAGE_W-1:0] p;
		int unsigned       leaf;
		bit                hit;
		int                i;
		if (page == 0)
			return ST_PAGE_ZERO;
		hit = 1'b0;
		for (i = 0; i < count; i++) begin
			p = page + PAGE_W'(i);
			// a page wrapped onto zero is skipped
			if (p != 0 && descend(p, 1'b0, leaf) == ST_OK && node_mirror[leaf][FRM]) begin
				node_mirror[leaf][FRM] = 1'b0;
				hit = 1'b1;
			end
		end
		return hit ? ST_OK : ST_NOT_MAPPED;
	endfunction

	// applies one command to the mirror and gives the result it should produce
	function automatic outcome_t command_outcome(command_row_t r);
		outcome_t          res;
		logic [PAGE_W-1:0] vpn;
		int unsigned       leaf;
		res.status = ST_NOT_MAPPED;
		res.pa = PA_ALL;
		case (r.cmd)
			CMD_MAP: res.status = map_run(r.page, r.frame, r.count);
			CMD_UNMAP: res.status = unmap_run(r.page, r.count);
			CMD_XLATE: begin
				vpn = r.va[VA_W-1:OFFSET_W];
				if (vpn != 0 && descend(vpn, 1'b0, leaf) == ST_OK && node_mirror[leaf][FRM]) begin
					res.pa = PA_W'({node_mirror[leaf][FRM-1:0], r.va[OFFSET_W-1:0]});
					res.status = ST_OK;
				end
			end
			default: ;
		endcase
		res.ok = (res.status == ST_OK);
		return res;
	endfunction

	// random command: mostly walks over the allocated paths, some pure noise
	function automatic command_row_t draw_command();
		command_row_t r;
		logic [8:0]   hi;
		logic [26:0]  low;
		int           kind;
		int           c;
		kind = $urandom_range(0, 99);
		hi = ($urandom_range(0, 15) == 0) ? 9'($urandom) : 9'($urandom_range(0, 5));
		low = PATH_BASE + 27'($urandom_range(0, 19));
		if ($urandom_range(0, 9) == 0) begin
			low = PATH_TOP;
			// top page of the space, so a run wraps onto page zero
			if ($urandom_range(0, 1) == 1)
				hi = 9'h1FF;
		end
		c = $urandom_range(0, 99);
		r.count = (c < 2) ? 10'($urandom_range(0, 1023)) :
			(c < 15) ? 10'($urandom_range(0, 24)) : 10'($urandom_range(0, 6));
		r.page = {hi, low};
		r.frame = FRAME_IN_W'($urandom);
		r.va = VA_W'({$urandom, $urandom});
		r.typed = 1'b0;
		r.ok = 1'b0;
		r.status = ST_OK;
		r.pa = '0;
		if (kind < 35) begin
			r.cmd = CMD_MAP;
		end else if (kind < 55) begin
			r.cmd = CMD_UNMAP;
		end else if (kind < 90) begin
			r.cmd = CMD_XLATE;
			r.va = {r.page, 12'($urandom)};
		end else begin
			r.cmd = CMD_W'($urandom_range(0, 3));
			r.page = PAGE_W'({$urandom, $urandom});
			r.count = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023)) :
				10'($urandom_range(0, 15));
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		error_count++;
	endtask

	// drives one command transaction, called and returning at a falling edge
	task automatic issue_command(command_row_t r);
		logic [IN_TDATA_W-1:0] d;
		outcome_t              want;
		d = '0;
		d[IN_PAGE_LSB +: PAGE_W] = r.page;
		d[IN_FRAME_LSB +: FRAME_IN_W] = r.frame;
		d[IN_COUNT_LSB +: COUNT_W] = r.count;
		d[IN_VA_LSB +: VA_W] = r.va;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.cmd;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		// accepted at this edge: update the mirror in acceptance order
		want = command_outcome(r);
		if (r.typed) begin
			want.ok = r.ok;
			want.status = r.status;
			want.pa = r.pa;
		end
		pending_outcomes.push_back(want);
		@(negedge clk);
	endtask

	// result side back-pressure, redrawn every cycle
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

	// result checker: every accepted transaction against the oldest expectation
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, tdata %h", m_axis_tdata));
			end else begin
				want = pending_outcomes.pop_front();
				if (m_axis_tdata[OUT_OK_BIT] !== want.ok)
					report_mismatch($sformatf("ok got %b want %b",
						m_axis_tdata[OUT_OK_BIT], want.ok));
				if (m_axis_tdata[OUT_ST_LSB +: STATUS_W] !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						m_axis_tdata[OUT_ST_LSB +: STATUS_W], want.status));
				if (m_axis_tdata[OUT_PA_LSB +: PA_W] !== want.pa)
					report_mismatch($sformatf("physical_address got %h want %h",
						m_axis_tdata[OUT_PA_LSB +: PA_W], want.pa));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[four_level_page_table_walker] ERROR");
			$finish;
		end
	end

	initial begin
		int i;
		for (i = 0; i < NODE_SLOTS; i++)
			node_mirror[i] = '0;
		mirror_next_node = 1;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// directed rows, slow sender and slower receiver; the clearing pass holds off the first
		foreach (directed_rows[k])
			issue_command(directed_rows[k]);

		// random traffic in three idling phases
		for (i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				tx_idle_pct = 52;
				rx_idle_pct = 38;
			end else if (i == 2 * N_RANDOM / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			issue_command(draw_command());
		end
		s_axis_tvalid <= 1'b0;

		// drain, then allow for stray results
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("[four_level_page_table_walker] OK");
		else
			$display("[four_level_page_table_walker] ERROR");
		$finish;
	end

endmodule
